// ----- rtl/tlca_pkg.sv -----
// package for the tree lca distance query unit: constants, opcodes and state codes
package tlca_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 11;
    localparam int NODE_W          = 10;
    localparam int DEPTH_W         = 10;
    localparam int DIST_W          = 32;
    localparam int OP_W            = 2;
    localparam int CNT_W           = 10;

    // item opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // result kinds
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OUT,
        ST_B_RD0,
        ST_B_WT0,
        ST_B_RD1,
        ST_B_WT1,
        ST_B_WR,
        ST_Q_RD,
        ST_Q_WT,
        ST_Q_ORD,
        ST_L_RD,
        ST_L_WT,
        ST_L_STEP,
        ST_L_DRD,
        ST_L_DWT,
        ST_B2_RD,
        ST_B2_WT,
        ST_B2_STEP,
        ST_F_RD,
        ST_F_WT,
        ST_D_RD,
        ST_D_WT,
        ST_D_MUL,
        ST_D_SUM
    } t_state;

endpackage

// ----- rtl/tree_lca_distance_query_unit.sv -----
// top level of the tree lca distance query unit: item sequencer and the three tables
// load: written into the tables when the item is accepted, no result beat
// build: for each level and node, reads the ancestor a level down, then that node's ancestor, and writes it
// query: depth read and ordering, lifting per level, second pass per level, then the distance result
// one item at a time; the next item is taken once the result beat has left the output register
// synchronous active-low reset clears control state only; tables are not cleared
module tree_lca_distance_query_unit
    import tlca_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], node[11:2], parent_node[21:12], node_depth[31:22],
    // root_distance[63:32], query_first[73:64], query_second[83:74], zero fill
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // common_ancestor[9:0], path_distance[41:10], zero fill
    output logic [47:0] m_axis_tdata,
    // result_kind[0]
    output logic        m_axis_tuser
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LVL_W = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int AADR_W = IDX_W + LVL_W;

    // tables
    logic [NODE_W-1:0]  anc_mem [2**AADR_W];
    logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
    logic [DIST_W-1:0]  dst_mem [MAX_NODES];

    // node number to table index (modulo max nodes)
    function automatic logic [IDX_W-1:0] f_idx(input logic [NODE_W-1:0] n);
        logic [31:0] w;
        w = 32'(n) % MAX_NODES;
        return w[IDX_W-1:0];
    endfunction

    // field unpacking
    logic [OP_W-1:0]    in_op;
    logic [NODE_W-1:0]  in_node, in_par, in_qa, in_qb;
    logic [DEPTH_W-1:0] in_dep;
    logic [DIST_W-1:0]  in_dst;
    assign in_op  = s_axis_tdata[1:0];
    assign in_node = s_axis_tdata[11:2];
    assign in_par = s_axis_tdata[21:12];
    assign in_dep = s_axis_tdata[31:22];
    assign in_dst = s_axis_tdata[63:32];
    assign in_qa  = s_axis_tdata[73:64];
    assign in_qb  = s_axis_tdata[83:74];

    t_state r_st, n_st;
    logic [CNT_W-1:0]   r_cnt;
    logic [LVL_W-1:0]   r_top;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_u, n_u, r_v, n_v, r_qa, r_qb;
    logic [NODE_W-1:0]  r_mid;
    logic [DEPTH_W-1:0] r_du, r_dv;
    logic [31:0]        r_diff;
    logic [DIST_W-1:0]  r_sum, r_da;
    logic               r_ovld;
    logic [NODE_W-1:0]  r_oanc;
    logic [DIST_W-1:0]  r_odst;
    logic               r_okind;

    // memory ports
    logic [AADR_W-1:0]  anc_ra, anc_ra2;
    logic [NODE_W-1:0]  anc_rd, anc_rd2;
    logic               anc_we;
    logic [AADR_W-1:0]  anc_wa;
    logic [NODE_W-1:0]  anc_wd;
    logic [IDX_W-1:0]   tab_ra, tab_rb;
    logic [DEPTH_W-1:0] dep_rd, dep_rd2;
    logic [DIST_W-1:0]  dst_rd, dst_rd2;

    function automatic logic [AADR_W-1:0] f_aadr(input logic [IDX_W-1:0] n,
                                                 input logic [LVL_W-1:0] l);
        return {n, l};
    endfunction

    logic acc_in;
    assign s_axis_tready = (r_st == ST_IDLE) && !r_ovld;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    // ancestor table, two read ports and one write port
    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            anc_mem[anc_wa] <= anc_wd;
        end
        anc_rd  <= anc_mem[anc_ra];
        anc_rd2 <= anc_mem[anc_ra2];
    end

    // depth and distance tables
    always_ff @(posedge i_clk) begin
        if (acc_in && in_op == OP_LOAD) begin
            dep_mem[f_idx(in_node)] <= in_dep;
            dst_mem[f_idx(in_node)] <= in_dst;
        end
        dep_rd  <= dep_mem[tab_ra];
        dst_rd  <= dst_mem[tab_ra];
        dep_rd2 <= dep_mem[tab_rb];
        dst_rd2 <= dst_mem[tab_rb];
    end

    // top lifting level from node count
    logic [LVL_W-1:0] top_c;
    always_comb begin
        top_c = '0;
        for (int t = 1; t < LIFT_LEVELS; t++) begin
            if (t < CNT_W && (r_cnt >> t) != '0) begin
                top_c = LVL_W'(t);
            end
        end
    end

    // lift step at the current level; wrapped differences stay above every step
    logic [31:0] step_w;
    assign step_w = 32'(1) << r_lvl;

    // memory address and write selection
    always_comb begin
        anc_we  = 1'b0;
        anc_wa  = f_aadr(f_idx(in_node), '0);
        anc_wd  = in_par;
        anc_ra  = f_aadr(r_u, r_lvl);
        anc_ra2 = f_aadr(r_v, r_lvl);
        tab_ra  = r_u;
        tab_rb  = r_v;
        unique case (r_st)
            ST_IDLE: begin
                anc_we = acc_in && in_op == OP_LOAD;
            end
            ST_B_RD0: begin
                anc_ra = f_aadr(f_idx(r_i), r_lvl - LVL_W'(1));
            end
            ST_B_RD1, ST_B_WT1: begin
                anc_ra = f_aadr(f_idx(r_mid), r_lvl - LVL_W'(1));
            end
            ST_B_WR: begin
                anc_we = 1'b1;
                anc_wa = f_aadr(f_idx(r_i), r_lvl);
                anc_wd = anc_rd;
            end
            ST_Q_RD, ST_Q_WT: begin
                tab_ra = r_qa;
                tab_rb = r_qb;
            end
            ST_F_RD: begin
                anc_ra = f_aadr(r_u, '0);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (acc_in) begin
                    if (in_op == OP_BUILD) begin
                        n_st = (top_c == '0) ? ST_OUT : ST_B_RD0;
                    end else if (in_op == OP_QUERY) begin
                        n_st = ST_Q_RD;
                    end
                end
            end
            ST_OUT:    n_st = ST_IDLE;
            ST_B_RD0:  n_st = ST_B_WT0;
            ST_B_WT0:  n_st = ST_B_RD1;
            ST_B_RD1:  n_st = ST_B_WT1;
            ST_B_WT1:  n_st = ST_B_WR;
            ST_B_WR: begin
                if (r_i == r_cnt && r_lvl == r_top) begin
                    n_st = ST_OUT;
                end else begin
                    n_st = ST_B_RD0;
                end
            end
            ST_Q_RD:   n_st = ST_Q_WT;
            ST_Q_WT:   n_st = ST_Q_ORD;
            ST_Q_ORD:  n_st = ST_L_RD;
            ST_L_RD:   n_st = ST_L_WT;
            ST_L_WT:   n_st = ST_L_STEP;
            ST_L_STEP: begin
                if (r_diff >= step_w) begin
                    n_st = ST_L_DRD;
                end else if (r_lvl == '0) begin
                    n_st = (r_u == r_v) ? ST_D_RD : ST_B2_RD;
                end else begin
                    n_st = ST_L_RD;
                end
            end
            ST_L_DRD:  n_st = ST_L_DWT;
            ST_L_DWT: begin
                if (r_lvl == '0) begin
                    n_st = (r_u == r_v) ? ST_D_RD : ST_B2_RD;
                end else begin
                    n_st = ST_L_RD;
                end
            end
            ST_B2_RD:  n_st = ST_B2_WT;
            ST_B2_WT:  n_st = ST_B2_STEP;
            ST_B2_STEP: n_st = (r_lvl == '0) ? ST_F_RD : ST_B2_RD;
            ST_F_RD:   n_st = ST_F_WT;
            ST_F_WT:   n_st = ST_D_RD;
            ST_D_RD:   n_st = ST_D_WT;
            ST_D_WT:   n_st = ST_D_MUL;
            ST_D_MUL:  n_st = ST_D_SUM;
            ST_D_SUM:  n_st = ST_OUT;
            default:   n_st = ST_IDLE;
        endcase
    end

    // datapath register updates
    always_comb begin
        n_u   = r_u;
        n_v   = r_v;
        n_lvl = r_lvl;
        n_i   = r_i;
        unique case (r_st)
            ST_IDLE: begin
                n_lvl = LVL_W'(1);
                n_i   = CNT_W'(1);
            end
            ST_B_WR: begin
                if (r_i == r_cnt) begin
                    n_i   = CNT_W'(1);
                    n_lvl = r_lvl + LVL_W'(1);
                end else begin
                    n_i = r_i + CNT_W'(1);
                end
            end
            ST_Q_ORD: begin
                n_lvl = r_top;
                if (dep_rd < dep_rd2) begin
                    n_u = r_qb;
                    n_v = r_qa;
                end else begin
                    n_u = r_qa;
                    n_v = r_qb;
                end
            end
            ST_L_STEP: begin
                if (r_diff >= step_w) begin
                    n_u = f_idx(anc_rd);
                end else if (r_lvl == '0) begin
                    n_lvl = r_top;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            ST_L_DWT: begin
                if (r_lvl == '0) begin
                    n_lvl = r_top;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            ST_B2_STEP: begin
                if (anc_rd != anc_rd2) begin
                    n_u = f_idx(anc_rd);
                    n_v = f_idx(anc_rd2);
                end
                if (r_lvl != '0) begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            ST_F_WT: begin
                n_u = f_idx(anc_rd);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_cnt  <= CNT_W'(1);
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (r_st == ST_OUT) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_lvl <= n_lvl;
        r_i   <= n_i;
        if (r_st == ST_B_WT0) begin
            r_mid <= anc_rd;
        end
        if (acc_in) begin
            r_top <= top_c;
            r_qa  <= f_idx(in_qa);
            r_qb  <= f_idx(in_qb);
            r_okind <= (in_op == OP_QUERY) ? KIND_QUERY : KIND_BUILD;
            r_oanc  <= '0;
            r_odst  <= '0;
        end
        if (r_st == ST_Q_WT) begin
            r_sum <= dst_rd + dst_rd2;
        end
        if (r_st == ST_Q_ORD) begin
            r_du <= (dep_rd < dep_rd2) ? dep_rd2 : dep_rd;
            r_dv <= (dep_rd < dep_rd2) ? dep_rd : dep_rd2;
        end
        if (r_st == ST_L_RD && r_lvl == r_top) begin
            r_diff <= 32'(r_du) - 32'(r_dv);
        end
        if (r_st == ST_L_DWT) begin
            r_diff <= 32'(dep_rd) - 32'(r_dv);
        end
        if (r_st == ST_D_WT) begin
            r_da <= dst_rd;
        end
        if (r_st == ST_D_MUL) begin
            r_da <= {r_da[DIST_W-2:0], 1'b0};
        end
        if (r_st == ST_D_SUM) begin
            r_oanc <= NODE_W'(r_u);
            r_odst <= r_sum - r_da;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {6'd0, r_odst, r_oanc};
    assign m_axis_tuser  = r_okind;

endmodule
